/* src/can_rx_id_monitor_table_defines.svh */
// Assertion macros of the identifier monitor table RTL.
// Included by cidm_ctrl, the only module that checks its own logic; no other dependencies.
`ifndef CAN_RX_ID_MONITOR_TABLE_DEFINES_SVH
`define CAN_RX_ID_MONITOR_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property checked at every rising edge outside reset.
`define CIDM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cidm assertion failed");

// Same-cycle implication checked at every rising edge outside reset.
`define CIDM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cidm implication failed");

`else

`define CIDM_ASSERT(label, clk, rst_n, prop)
`define CIDM_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/cidm_pkg.sv */
// Types, codes and constants of the CAN receive identifier monitor table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cidm_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 32;

    localparam int BUS_W    = 2;
    localparam int STD_ID_W = 11;
    localparam int ID_W     = 29;
    localparam int HITS_W   = 32;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [2:0] {
        RES_COUNTED = 3'd0,
        RES_NEW     = 3'd1,
        RES_FULL    = 3'd2,
        RES_POPPED  = 3'd3,
        RES_NONE    = 3'd4
    } result_code_t;

    typedef struct packed {
        logic                cmd;
        logic [BUS_W-1:0]    bus_number;
        logic                extended_format;
        logic [STD_ID_W-1:0] std_id;
        logic [ID_W-1:0]     ext_id;
    } in_item_t;

    typedef struct packed {
        result_code_t        result_code;
        logic [BUS_W-1:0]    out_bus;
        logic                out_extended;
        logic [ID_W-1:0]     out_identifier;
        logic [HITS_W-1:0]   out_hits;
    } out_item_t;

    // One table entry as held in the memory.
    typedef struct packed {
        logic [BUS_W-1:0]  bus;
        logic              extended;
        logic [ID_W-1:0]   identifier;
        logic [HITS_W-1:0] hits;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_INSERT,
        ST_POP_RD,
        ST_POP_DATA,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* src/cidm_mem.sv */
// Entry memory of the identifier table: one write port, one read port,
// registered read data. Depends on cidm_pkg.
`default_nettype none

module cidm_mem #(
    parameter int ENTRIES = cidm_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output cidm_pkg::entry_t       rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire cidm_pkg::entry_t  wr_data
);
    import cidm_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/cidm_ctrl.sv */
// Sequencer of the identifier table: key scan, insert, pop and fill pointers.
// Depends on cidm_pkg and can_rx_id_monitor_table_defines.svh.
`default_nettype none

module cidm_ctrl #(
    parameter int ENTRIES = cidm_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire cidm_pkg::in_item_t req,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output cidm_pkg::out_item_t   res,
    output logic                  mem_rd_en,
    output logic [IDX_W-1:0]      mem_rd_addr,
    input  wire cidm_pkg::entry_t mem_rd_data,
    output logic                  mem_wr_en,
    output logic [IDX_W-1:0]      mem_wr_addr,
    output cidm_pkg::entry_t      mem_wr_data
);
    import cidm_pkg::*;

`include "can_rx_id_monitor_table_defines.svh"

    // Entries are never freed, so the used ones form a prefix of the table
    // and the reported ones a prefix of those. Two pointers replace the marks.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pop_reg, pop_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [BUS_W-1:0]  bus_reg, bus_next;
    logic              ext_reg, ext_next;
    logic [ID_W-1:0]   id_reg, id_next;
    out_item_t         res_reg, res_next;

    logic [CNT_W-1:0]  scan_inc;
    logic              key_match;
    logic              table_full;

    assign scan_inc   = scan_reg + CNT_W'(1);
    assign table_full = (count_reg == CNT_W'(ENTRIES));
    assign key_match  = (mem_rd_data.bus == bus_reg) && (mem_rd_data.extended == ext_reg)
                        && (mem_rd_data.identifier == id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pop_reg   <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pop_reg   <= pop_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
        ext_reg <= ext_next;
        id_reg  <= id_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pop_next    = pop_reg;
        scan_next   = scan_reg;
        bus_next    = bus_reg;
        ext_next    = ext_reg;
        id_next     = id_reg;
        res_next    = res_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = scan_reg[IDX_W-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = scan_reg[IDX_W-1:0];
        mem_wr_data = mem_rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    bus_next = req.bus_number;
                    ext_next = req.extended_format;
                    id_next  = req.extended_format ? req.ext_id
                               : {{(ID_W - STD_ID_W){1'b0}}, req.std_id};
                    res_next = '0;
                    if (req.cmd == CMD_POP)
                    begin
                        if (pop_reg != count_reg)
                        begin
                            state_next = ST_POP_RD;
                        end
                        else
                        begin
                            res_next.result_code = RES_NONE;
                            state_next           = ST_DONE;
                        end
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = (count_reg == '0) ? ST_INSERT : ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (key_match)
                begin
                    mem_wr_en            = 1'b1;
                    mem_wr_data.hits     = mem_rd_data.hits + HITS_W'(1);
                    res_next.result_code = RES_COUNTED;
                    state_next           = ST_DONE;
                end
                else if (scan_inc == count_reg)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    scan_next  = scan_inc;
                    state_next = ST_READ;
                end
            end
            ST_INSERT:
            begin
                if (table_full)
                begin
                    res_next.result_code = RES_FULL;
                end
                else
                begin
                    mem_wr_en              = 1'b1;
                    mem_wr_addr            = count_reg[IDX_W-1:0];
                    mem_wr_data.bus        = bus_reg;
                    mem_wr_data.extended   = ext_reg;
                    mem_wr_data.identifier = id_reg;
                    mem_wr_data.hits       = HITS_W'(1);
                    count_next             = count_reg + CNT_W'(1);
                    res_next.result_code   = RES_NEW;
                end
                state_next = ST_DONE;
            end
            ST_POP_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pop_reg[IDX_W-1:0];
                state_next  = ST_POP_DATA;
            end
            ST_POP_DATA:
            begin
                res_next.result_code    = RES_POPPED;
                res_next.out_bus        = mem_rd_data.bus;
                res_next.out_extended   = mem_rd_data.extended;
                res_next.out_identifier = mem_rd_data.identifier;
                res_next.out_hits       = mem_rd_data.hits;
                pop_next                = pop_reg + CNT_W'(1);
                state_next              = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    `CIDM_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(ENTRIES))
    `CIDM_ASSERT(a_pop_bound, clk, rst_n, pop_reg <= count_reg)
    `CIDM_ASSERT_IMPL(a_count_step, clk, rst_n, count_reg != $past(count_reg),
                      count_reg == $past(count_reg) + CNT_W'(1))
    `CIDM_ASSERT_IMPL(a_write_state, clk, rst_n, mem_wr_en,
                      state_reg == ST_CMP || state_reg == ST_INSERT)

endmodule

`default_nettype wire

/* src/can_rx_id_monitor_table.sv */
// Channel  | Payload               | Handshake
// req      | cidm_pkg::in_item_t   | req_valid / req_stall
// rsp      | cidm_pkg::out_item_t  | rsp_valid / rsp_stall
//
// A pop reads its entry, then loads the data into its result; an empty pop reads nothing.
// A record scans the used entries one memory read and one compare at a time; a new key
// or a full table then goes to the insert step, and a match writes back its hit count.
// The next item is taken in the cycle after its result is loaded into the output register.
// Reset clears the state, the pointers and rsp_valid; no clearing pass is needed.
// A new item is taken while the previous result still waits under rsp_stall.
// Depends on cidm_pkg, cidm_mem and cidm_ctrl.
`default_nettype none

module can_rx_id_monitor_table #(
    parameter int TABLE_ENTRIES = cidm_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire cidm_pkg::in_item_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output cidm_pkg::out_item_t      rsp
);
    import cidm_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic              res_valid;
    logic              res_ready;
    out_item_t         res;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    entry_t            mem_rd_data;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    entry_t            mem_wr_data;

    logic              rsp_valid_reg, rsp_valid_next;
    out_item_t         rsp_reg;
    logic              load;

    cidm_ctrl #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    cidm_mem #(
        .ENTRIES (TABLE_ENTRIES),
        .ADDR_W  (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // The output register is free when empty or when its item leaves now.
    assign res_ready = !rsp_valid_reg || !rsp_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
